// ===== src/rtmh_pkg.sv =====
// ----------------------------------------------------------------------------
// rtmh_pkg - shared constants for the ray / triangle-mesh hit block
// Configuration register indexes, multiplier tile size, queue depth.
// ----------------------------------------------------------------------------
package rtmh_pkg;

    localparam int COORD_BITS_DEF = 32;     // default coordinate width
    localparam int DIGIT_BITS     = 32;     // multiplier tile width
    localparam int QUEUE_DEPTH    = 4;      // front/back queue, power of two
    localparam int CFG_ADDR_BITS  = 3;
    localparam int CFG_DATA_BITS  = 32;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_ORIGIN_X  = 3'd0,
        CFG_ORIGIN_Y  = 3'd1,
        CFG_ORIGIN_Z  = 3'd2,
        CFG_DIR_X     = 3'd3,
        CFG_DIR_Y     = 3'd4,
        CFG_DIR_Z     = 3'd5,
        CFG_THRESHOLD = 3'd6
    } t_cfg_idx;

endpackage

// ===== src/rtmh_mul.sv =====
// ----------------------------------------------------------------------------
// rtmh_mul - pipelined signed multiplier
// Operands cut into tiles, tile products registered, then a registered
// adder tree, padded with pass-through levels up to the LAT depth.
// ----------------------------------------------------------------------------
module rtmh_mul
    import rtmh_pkg::*;
#(
    parameter int AW  = 33,
    parameter int BW  = 33,
    parameter int LAT = 2
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [AW-1:0]      i_a,
    input  logic signed [BW-1:0]      i_b,
    output logic signed [AW+BW-1:0]   o_p
);

    localparam int T  = DIGIT_BITS;
    localparam int NA = (AW + T - 1) / T;
    localparam int NB = (BW + T - 1) / T;
    localparam int NP = NA * NB;
    localparam int PW = AW + BW;

    logic [NA*T-1:0] w_ax;
    logic [NB*T-1:0] w_bx;
    logic [PW-1:0]   r_tr [LAT][NP];

    assign w_ax = (NA*T)'(i_a);
    assign w_bx = (NB*T)'(i_b);

    // tile products: lower digits unsigned, top digit carries the sign
    for (genvar ga = 0; ga < NA; ga++) begin : g_a
        for (genvar gb = 0; gb < NB; gb++) begin : g_b
            logic signed [T:0]     w_da;
            logic signed [T:0]     w_db;
            logic signed [2*T+1:0] w_pp;
            if (ga == NA - 1) begin : g_sa
                assign w_da = $signed({w_ax[ga*T+T-1], w_ax[ga*T +: T]});
            end else begin : g_ua
                assign w_da = $signed({1'b0, w_ax[ga*T +: T]});
            end
            if (gb == NB - 1) begin : g_sb
                assign w_db = $signed({w_bx[gb*T+T-1], w_bx[gb*T +: T]});
            end else begin : g_ub
                assign w_db = $signed({1'b0, w_bx[gb*T +: T]});
            end
            assign w_pp = w_da * w_db;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_tr[0][ga*NB+gb] <= PW'(w_pp) << ((ga + gb) * T);
                end
            end
        end
    end

    // pairwise tree, each level registered; surplus levels just pass
    for (genvar gl = 0; gl < LAT - 1; gl++) begin : g_lv
        localparam int CC = (NP + (1 << gl) - 1) >> gl;
        localparam int CN = (NP + (1 << (gl + 1)) - 1) >> (gl + 1);
        for (genvar gk = 0; gk < CN; gk++) begin : g_nd
            if (2 * gk + 1 < CC) begin : g_add
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_tr[gl+1][gk] <= r_tr[gl][2*gk] + r_tr[gl][2*gk+1];
                    end
                end
            end else begin : g_pass
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_tr[gl+1][gk] <= r_tr[gl][2*gk];
                    end
                end
            end
        end
    end

    assign o_p = r_tr[LAT-1][0];

endmodule

// ===== src/rtmh_fifo.sv =====
// ----------------------------------------------------------------------------
// rtmh_fifo - short queue between front and back
// Flop storage, registered pointers, full/valid from a fill count.
// ----------------------------------------------------------------------------
module rtmh_fifo
    import rtmh_pkg::*;
#(
    parameter type t_data = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_data o_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_data         r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== src/rtmh_front.sv =====
// ----------------------------------------------------------------------------
// rtmh_front - triangle intake
// Takes a triangle beat, forms edges and origin offsets, pushes to queue.
// ----------------------------------------------------------------------------
module rtmh_front
    import rtmh_pkg::*;
#(
    parameter int  COORD_BITS = COORD_BITS_DEF,
    parameter type t_tri      = logic
) (
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [2:0][2:0][CFG_DATA_BITS-1:0]     i_vtx,
    input  logic                                   i_last,
    input  logic [2:0][COORD_BITS-1:0]             i_origin,
    input  logic                                   i_full,
    output logic                                   o_push,
    output t_tri                                   o_item
);

    localparam int C  = COORD_BITS;
    localparam int E  = C + 1;
    localparam int PW = (C > CFG_DATA_BITS) ? C : CFG_DATA_BITS;

    logic [2:0][2:0][C-1:0] w_v;

    // coordinates are the low C bits, read as signed
    for (genvar k = 0; k < 3; k++) begin : g_k
        for (genvar i = 0; i < 3; i++) begin : g_i
            logic [PW-1:0] w_z;
            assign w_z       = PW'($unsigned(i_vtx[k][i]));
            assign w_v[k][i] = w_z[C-1:0];
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_item      = '0;
        o_item.last = i_last;
        for (int i = 0; i < 3; i++) begin
            o_item.e[0][i] = E'($signed(w_v[1][i])) - E'($signed(w_v[0][i]));
            o_item.e[1][i] = E'($signed(w_v[2][i])) - E'($signed(w_v[1][i]));
            o_item.e[2][i] = E'($signed(w_v[0][i])) - E'($signed(w_v[2][i]));
            o_item.ac[i]   = E'($signed(w_v[2][i])) - E'($signed(w_v[0][i]));
            o_item.ao[i]   = E'($signed(w_v[0][i])) - E'($signed(i_origin[i]));
            for (int k = 0; k < 3; k++) begin
                o_item.oc[k][i] = E'($signed(i_origin[i])) - E'($signed(w_v[k][i]));
            end
        end
    end

endmodule

// ===== src/rtmh_back.sv =====
// ----------------------------------------------------------------------------
// rtmh_back - intersection pipeline
// Five multiply phases (normal, plane, hit point, edge cross, edge dot),
// miss flags, sticky hit and result register. One global stall.
// ----------------------------------------------------------------------------
module rtmh_back
    import rtmh_pkg::*;
#(
    parameter int  COORD_BITS = COORD_BITS_DEF,
    parameter type t_tri      = logic
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_item_valid,
    input  t_tri                       i_item,
    output logic                       o_item_pop,
    input  logic [2:0][COORD_BITS-1:0] i_dir,
    input  logic [CFG_DATA_BITS-1:0]   i_threshold,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output logic                       o_mesh_hit
);

    localparam int C   = COORD_BITS;
    localparam int E   = C + 1;          // edges, offsets
    localparam int N   = 2 * C + 3;      // normal
    localparam int D   = 3 * C + 5;      // n.dir
    localparam int U   = 3 * C + 6;      // n.(A-origin)
    localparam int Q   = 4 * C + 7;      // scaled hit point offset
    localparam int X   = 5 * C + 9;      // edge cross
    localparam int S   = 7 * C + 14;     // edge dot
    localparam int T   = DIGIT_BITS;
    localparam int LAT = 1 + $clog2(((N + T - 1) / T) * ((X + T - 1) / T));

    typedef struct packed {
        t_tri              item;
        logic [2:0][N-1:0] n;
        logic              neg;
        logic              miss;
    } t_ctx;

    logic en;
    logic r_out_valid;
    logic r_out_hit;
    logic r_sticky;

    t_ctx r_c0, r_c1, r_c2, r_c3, r_c4;
    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5;
    logic r_hit, r_last;

    logic [D-1:0]           r_ndd;
    logic [U-1:0]           r_num;
    logic [2:0][2:0][Q-1:0] r_q;
    logic [2:0][2:0][X-1:0] r_x;

    t_ctx w_cin [5];
    logic w_vin [5];
    t_ctx r_dl  [5][LAT];
    logic r_dv  [5][LAT];

    // stall only when a result waits and is not taken
    assign en         = !(r_out_valid && !i_res_ready);
    assign o_item_pop = en && i_item_valid;

    // stage 0: from queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c0.item <= i_item;
            r_c0.n    <= '0;
            r_c0.neg  <= 1'b0;
            r_c0.miss <= 1'b0;
        end
    end

    // context delay lines, matched to multiplier latency
    t_ctx n_c2;
    assign w_cin[0] = r_c0;
    assign w_cin[1] = r_c1;
    assign w_cin[2] = n_c2;
    assign w_cin[3] = r_c3;
    assign w_cin[4] = r_c4;
    assign w_vin[0] = r_v0;
    assign w_vin[1] = r_v1;
    assign w_vin[2] = r_v2;
    assign w_vin[3] = r_v3;
    assign w_vin[4] = r_v4;

    for (genvar p = 0; p < 5; p++) begin : g_dl
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dl[p][0] <= w_cin[p];
                for (int s = 1; s < LAT; s++) begin
                    r_dl[p][s] <= r_dl[p][s-1];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                for (int s = 0; s < LAT; s++) begin
                    r_dv[p][s] <= 1'b0;
                end
            end else if (en) begin
                r_dv[p][0] <= w_vin[p];
                for (int s = 1; s < LAT; s++) begin
                    r_dv[p][s] <= r_dv[p][s-1];
                end
            end
        end
    end

    // phase 0: n = e0 x (C-A)
    logic signed [2*E-1:0] w_na [3];
    logic signed [2*E-1:0] w_nb [3];
    for (genvar i = 0; i < 3; i++) begin : g_n
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;
        rtmh_mul #(.AW(E), .BW(E), .LAT(LAT)) u_na (
            .i_clk(i_clk), .i_en(en),
            .i_a(r_c0.item.e[0][J]), .i_b(r_c0.item.ac[K]), .o_p(w_na[i])
        );
        rtmh_mul #(.AW(E), .BW(E), .LAT(LAT)) u_nb (
            .i_clk(i_clk), .i_en(en),
            .i_a(r_c0.item.e[0][K]), .i_b(r_c0.item.ac[J]), .o_p(w_nb[i])
        );
    end

    t_ctx n_c1;
    always_comb begin
        n_c1 = r_dl[0][LAT-1];
        for (int i = 0; i < 3; i++) begin
            n_c1.n[i] = N'(w_na[i]) - N'(w_nb[i]);
        end
    end

    // phase 1: n.dir and n.(A-origin)
    logic signed [N+C-1:0] w_dd [3];
    logic signed [N+E-1:0] w_nm [3];
    for (genvar i = 0; i < 3; i++) begin : g_d
        rtmh_mul #(.AW(N), .BW(C), .LAT(LAT)) u_dd (
            .i_clk(i_clk), .i_en(en),
            .i_a(r_c1.n[i]), .i_b(i_dir[i]), .o_p(w_dd[i])
        );
        rtmh_mul #(.AW(N), .BW(E), .LAT(LAT)) u_nm (
            .i_clk(i_clk), .i_en(en),
            .i_a(r_c1.n[i]), .i_b(r_c1.item.ao[i]), .o_p(w_nm[i])
        );
    end

    // plane tests: parallel, zero n.dir, hit behind origin
    logic         n_neg;
    logic [D-1:0] n_mag;
    always_comb begin
        n_neg     = r_ndd[D-1];
        n_mag     = n_neg ? (r_ndd ^ {D{1'b1}}) + 1'b1 : r_ndd;
        n_c2      = r_c2;
        n_c2.neg  = n_neg;
        n_c2.miss = (r_ndd == '0) || (n_mag < D'(i_threshold))
                    || ((r_num != '0) && (r_num[U-1] != n_neg));
    end

    // phase 2: q_k = (origin - v_k) * n.dir + dir * num
    logic signed [E+D-1:0] w_qa [3][3];
    logic signed [C+U-1:0] w_qb [3];
    for (genvar i = 0; i < 3; i++) begin : g_qb
        rtmh_mul #(.AW(C), .BW(U), .LAT(LAT)) u_qb (
            .i_clk(i_clk), .i_en(en),
            .i_a(i_dir[i]), .i_b(r_num), .o_p(w_qb[i])
        );
    end
    for (genvar k = 0; k < 3; k++) begin : g_qk
        for (genvar i = 0; i < 3; i++) begin : g_qi
            rtmh_mul #(.AW(E), .BW(D), .LAT(LAT)) u_qa (
                .i_clk(i_clk), .i_en(en),
                .i_a(n_c2.item.oc[k][i]), .i_b(r_ndd), .o_p(w_qa[k][i])
            );
        end
    end

    // phase 3: x_k = e_k x q_k
    logic signed [E+Q-1:0] w_xa [3][3];
    logic signed [E+Q-1:0] w_xb [3][3];
    for (genvar k = 0; k < 3; k++) begin : g_xk
        for (genvar i = 0; i < 3; i++) begin : g_xi
            localparam int J = (i + 1) % 3;
            localparam int L = (i + 2) % 3;
            rtmh_mul #(.AW(E), .BW(Q), .LAT(LAT)) u_xa (
                .i_clk(i_clk), .i_en(en),
                .i_a(r_c3.item.e[k][J]), .i_b(r_q[k][L]), .o_p(w_xa[k][i])
            );
            rtmh_mul #(.AW(E), .BW(Q), .LAT(LAT)) u_xb (
                .i_clk(i_clk), .i_en(en),
                .i_a(r_c3.item.e[k][L]), .i_b(r_q[k][J]), .o_p(w_xb[k][i])
            );
        end
    end

    // phase 4: n . x_k
    logic signed [N+X-1:0] w_s [3][3];
    for (genvar k = 0; k < 3; k++) begin : g_sk
        for (genvar i = 0; i < 3; i++) begin : g_si
            rtmh_mul #(.AW(N), .BW(X), .LAT(LAT)) u_s (
                .i_clk(i_clk), .i_en(en),
                .i_a(r_c4.n[i]), .i_b(r_x[k][i]), .o_p(w_s[k][i])
            );
        end
    end

    t_ctx         w_c5;
    logic [S-1:0] n_sum [3];
    logic         n_hit;
    always_comb begin
        w_c5  = r_dl[4][LAT-1];
        n_hit = !w_c5.miss;
        for (int k = 0; k < 3; k++) begin
            n_sum[k] = S'(w_s[k][0]) + S'(w_s[k][1]) + S'(w_s[k][2]);
            if ((n_sum[k] != '0) && (n_sum[k][S-1] != w_c5.neg)) begin
                n_hit = 1'b0;
            end
        end
    end

    // stage registers between phases
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1  <= n_c1;
            r_c2  <= r_dl[1][LAT-1];
            r_ndd <= D'(w_dd[0]) + D'(w_dd[1]) + D'(w_dd[2]);
            r_num <= U'(w_nm[0]) + U'(w_nm[1]) + U'(w_nm[2]);
            r_c3  <= r_dl[2][LAT-1];
            r_c4  <= r_dl[3][LAT-1];
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_q[k][i] <= Q'(w_qa[k][i]) + Q'(w_qb[i]);
                    r_x[k][i] <= X'(w_xa[k][i]) - X'(w_xb[k][i]);
                end
            end
            r_hit  <= n_hit;
            r_last <= w_c5.item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= r_dv[0][LAT-1];
            r_v2 <= r_dv[1][LAT-1];
            r_v3 <= r_dv[2][LAT-1];
            r_v4 <= r_dv[3][LAT-1];
            r_v5 <= r_dv[4][LAT-1];
        end
    end

    // sticky hit and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sticky    <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_v5 && r_last;
            if (r_v5) begin
                r_sticky <= r_last ? 1'b0 : (r_sticky | r_hit);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_v5 && r_last) begin
            r_out_hit <= r_sticky | r_hit;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_mesh_hit  = r_out_hit;

endmodule

// ===== src/ray_triangle_mesh_hit_top.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_mesh_hit_top - ray against triangle mesh, any-hit test
// Config registers, intake, queue and intersection pipeline.
// ----------------------------------------------------------------------------
// A ray (origin, direction) and a parallel threshold sit in config registers,
// written through a plain write port; the user must write them only while
// the block is idle, which the block itself does not enforce. Triangles
// stream in one beat each; the beat flagged last closes the mesh, and one
// result beat per closed mesh says whether any triangle of that mesh was hit.
// Arithmetic is exact integer on the Q16.16 inputs, so near-edge and t = 0
// hits count as hits. Rate: one triangle per clock, sustained while no
// result is held. After the last triangle is taken, it passes the intake
// queue and the five chained multiply phases before its result beat. A held
// result stalls the whole pipeline; the intake queue keeps taking beats
// until it fills.
// ----------------------------------------------------------------------------
module ray_triangle_mesh_hit_top
    import rtmh_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // triangle channel
    input  logic                       i_tri_valid,
    output logic                       o_tri_ready,
    input  logic signed [31:0]         i_a_x,
    input  logic signed [31:0]         i_a_y,
    input  logic signed [31:0]         i_a_z,
    input  logic signed [31:0]         i_b_x,
    input  logic signed [31:0]         i_b_y,
    input  logic signed [31:0]         i_b_z,
    input  logic signed [31:0]         i_c_x,
    input  logic signed [31:0]         i_c_y,
    input  logic signed [31:0]         i_c_z,
    input  logic                       i_last_triangle,
    // result channel
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output logic                       o_mesh_hit,
    // config write port
    input  logic                       i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]   i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]   i_cfg_wdata
);

    localparam int C  = COORD_BITS;
    localparam int E  = C + 1;
    localparam int PW = (C > CFG_DATA_BITS) ? C : CFG_DATA_BITS;

    // queued triangle: edges, C-A, A-origin and origin-vertex offsets
    typedef struct packed {
        logic [2:0][2:0][E-1:0] e;
        logic [2:0][E-1:0]      ac;
        logic [2:0][E-1:0]      ao;
        logic [2:0][2:0][E-1:0] oc;
        logic                   last;
    } t_tri;

    logic [2:0][CFG_DATA_BITS-1:0] r_origin;
    logic [2:0][CFG_DATA_BITS-1:0] r_dir;
    logic [CFG_DATA_BITS-1:0]      r_thr;

    // config registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin <= '0;
            r_dir    <= '0;
            r_thr    <= CFG_DATA_BITS'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_ORIGIN_X:  r_origin[0] <= i_cfg_wdata;
                CFG_ORIGIN_Y:  r_origin[1] <= i_cfg_wdata;
                CFG_ORIGIN_Z:  r_origin[2] <= i_cfg_wdata;
                CFG_DIR_X:     r_dir[0]    <= i_cfg_wdata;
                CFG_DIR_Y:     r_dir[1]    <= i_cfg_wdata;
                CFG_DIR_Z:     r_dir[2]    <= i_cfg_wdata;
                CFG_THRESHOLD: r_thr       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ray as signed C-bit values from the low register bits
    logic [2:0][C-1:0] w_origin;
    logic [2:0][C-1:0] w_dir;
    for (genvar i = 0; i < 3; i++) begin : g_ray
        logic [PW-1:0] w_zo;
        logic [PW-1:0] w_zd;
        assign w_zo        = PW'(r_origin[i]);
        assign w_zd        = PW'(r_dir[i]);
        assign w_origin[i] = w_zo[C-1:0];
        assign w_dir[i]    = w_zd[C-1:0];
    end

    logic [2:0][2:0][CFG_DATA_BITS-1:0] w_vtx;
    assign w_vtx[0] = {i_a_z, i_a_y, i_a_x};
    assign w_vtx[1] = {i_b_z, i_b_y, i_b_x};
    assign w_vtx[2] = {i_c_z, i_c_y, i_c_x};

    logic w_full, w_push, w_qvalid, w_pop;
    t_tri w_item_in, w_item_out;

    rtmh_front #(.COORD_BITS(C), .t_tri(t_tri)) u_front (
        .i_valid  (i_tri_valid),
        .o_ready  (o_tri_ready),
        .i_vtx    (w_vtx),
        .i_last   (i_last_triangle),
        .i_origin (w_origin),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_item   (w_item_in)
    );

    rtmh_fifo #(.t_data(t_tri)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_item_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_data  (w_item_out)
    );

    rtmh_back #(.COORD_BITS(C), .t_tri(t_tri)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_qvalid),
        .i_item       (w_item_out),
        .o_item_pop   (w_pop),
        .i_dir        (w_dir),
        .i_threshold  (r_thr),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_mesh_hit   (o_mesh_hit)
    );

endmodule

// ===== dv/ray_triangle_mesh_hit_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_mesh_hit_top_tb - any-hit ray/mesh test bench
// Streams triangle meshes through the block under several ray setups and
// back-pressure patterns. An exact wide-integer model predicts one hit bit
// per closed mesh; every result beat is checked against it in order.
// ----------------------------------------------------------------------------
module ray_triangle_mesh_hit_top_tb;
    import rtmh_pkg::*;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE = 3'd7;  // no such register
    localparam int ONE = 1 << 16;                            // 1.0 in Q16.16

    // 320 bits covers the widest edge-test product with room to spare
    typedef logic signed [319:0] wint_t;
    typedef struct packed {
        wint_t x;
        wint_t y;
        wint_t z;
    } vec_t;

    typedef struct packed {
        logic signed [31:0] ax, ay, az;
        logic signed [31:0] bx, by, bz;
        logic signed [31:0] cx, cy, cz;
        logic               last;
    } tri_t;

    logic                     clk;
    logic                     rst_n;
    logic                     tri_vld;
    logic                     tri_rdy;
    tri_t                     tri_out;
    logic                     res_vld;
    logic                     res_rdy;
    logic                     mesh_hit;
    logic                     cfg_we;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;

    ray_triangle_mesh_hit_top u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_tri_valid     (tri_vld),
        .o_tri_ready     (tri_rdy),
        .i_a_x           (tri_out.ax),
        .i_a_y           (tri_out.ay),
        .i_a_z           (tri_out.az),
        .i_b_x           (tri_out.bx),
        .i_b_y           (tri_out.by),
        .i_b_z           (tri_out.bz),
        .i_c_x           (tri_out.cx),
        .i_c_y           (tri_out.cy),
        .i_c_z           (tri_out.cz),
        .i_last_triangle (tri_out.last),
        .o_res_valid     (res_vld),
        .i_res_ready     (res_rdy),
        .o_mesh_hit      (mesh_hit),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Shadow of the ray registers and the sticky hit bit
    // ------------------------------------------------------------------------
    logic [31:0] ray_reg [0:6];
    logic        hit_acc;
    logic        mesh_hit_q [$];   // expected hit bit per closed mesh
    tri_t        tri_pend [$];     // triangles waiting for the driver
    int          send_idle;        // percent of cycles the sender sits out
    int          recv_stall;       // percent of cycles the receiver stalls
    bit          long_hold_req;
    bit          long_hold_done;
    int          hold_cnt;
    int          n_err;

    function automatic wint_t sx(logic signed [31:0] v);
        return wint_t'(v);
    endfunction

    function automatic vec_t vsub(vec_t p, vec_t q);
        vec_t r;
        r.x = p.x - q.x;
        r.y = p.y - q.y;
        r.z = p.z - q.z;
        return r;
    endfunction

    function automatic vec_t vcross(vec_t p, vec_t q);
        vec_t r;
        r.x = p.y * q.z - p.z * q.y;
        r.y = p.z * q.x - p.x * q.z;
        r.z = p.x * q.y - p.y * q.x;
        return r;
    endfunction

    function automatic wint_t vdot(vec_t p, vec_t q);
        return p.x * q.x + p.y * q.y + p.z * q.z;
    endfunction

    function automatic bit opposite(wint_t p, wint_t q);
        return (p < 0 && q > 0) || (p > 0 && q < 0);
    endfunction

    // Exact geometric test: no division; t < 0 and the inside tests are done
    // on sign products scaled by n.dir.
    function automatic bit ray_hits_tri(tri_t t);
        vec_t  vtx [3];
        vec_t  edg [3];
        vec_t  org, dir, nrm, oc, q;
        wint_t ndd, num, mag;
        vtx[0] = '{sx(t.ax), sx(t.ay), sx(t.az)};
        vtx[1] = '{sx(t.bx), sx(t.by), sx(t.bz)};
        vtx[2] = '{sx(t.cx), sx(t.cy), sx(t.cz)};
        org = '{sx(ray_reg[CFG_ORIGIN_X]), sx(ray_reg[CFG_ORIGIN_Y]),
                sx(ray_reg[CFG_ORIGIN_Z])};
        dir = '{sx(ray_reg[CFG_DIR_X]), sx(ray_reg[CFG_DIR_Y]),
                sx(ray_reg[CFG_DIR_Z])};
        edg[0] = vsub(vtx[1], vtx[0]);
        edg[1] = vsub(vtx[2], vtx[1]);
        edg[2] = vsub(vtx[0], vtx[2]);
        nrm = vcross(edg[0], vsub(vtx[2], vtx[0]));
        ndd = vdot(nrm, dir);
        if (ndd == 0) return 0;
        mag = (ndd < 0) ? -ndd : ndd;
        if (mag < wint_t'({1'b0, ray_reg[CFG_THRESHOLD]})) return 0;
        num = vdot(nrm, vsub(vtx[0], org));
        if (opposite(num, ndd)) return 0;
        for (int k = 0; k < 3; k++) begin
            oc = vsub(org, vtx[k]);
            q.x = oc.x * ndd + dir.x * num;
            q.y = oc.y * ndd + dir.y * num;
            q.z = oc.z * ndd + dir.z * num;
            if (opposite(vdot(nrm, vcross(edg[k], q)), ndd)) return 0;
        end
        return 1;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, and time-out guard
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: one triangle beat held until taken; prediction at acceptance
    // ------------------------------------------------------------------------
    tri_t cur_tri;

    always @(posedge clk) begin
        if (rst_n) begin
            if (tri_vld && tri_rdy) begin
                if (ray_hits_tri(cur_tri)) hit_acc = 1'b1;
                if (cur_tri.last) begin
                    mesh_hit_q.push_back(hit_acc);
                    hit_acc = 1'b0;
                end
            end
            if (!tri_vld || tri_rdy) begin
                if (tri_pend.size() > 0 && $urandom_range(99) >= send_idle) begin
                    cur_tri = tri_pend.pop_front();
                    tri_out <= cur_tri;
                    tri_vld <= 1'b1;
                end else begin
                    tri_vld <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long receiver hold: lets the pipeline and intake queue fill up
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (long_hold_req && !long_hold_done) begin
                hold_cnt       <= 400;
                long_hold_done <= 1'b1;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: result beats against the expected queue; ready pattern
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        logic exp_hit;
        if (rst_n) begin
            if (res_vld && res_rdy) begin
                if (mesh_hit_q.size() == 0) begin
                    $display("%0t: result beat with none expected, got %0b",
                             $time, mesh_hit);
                    n_err++;
                end else begin
                    exp_hit = mesh_hit_q.pop_front();
                    if (mesh_hit !== exp_hit) begin
                        $display("%0t: mesh_hit expected %0b got %0b",
                                 $time, exp_hit, mesh_hit);
                        n_err++;
                    end
                end
            end
            if (hold_cnt > 0) begin
                res_rdy <= 1'b0;
            end else begin
                res_rdy <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic signed [31:0] near(int span);
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    task automatic cfg_write(logic [CFG_ADDR_BITS-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx <= CFG_THRESHOLD) ray_reg[idx] = val;
    endtask

    task automatic cfg_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                           logic [31:0] thr);
        cfg_write(CFG_ORIGIN_X, ox);
        cfg_write(CFG_ORIGIN_Y, oy);
        cfg_write(CFG_ORIGIN_Z, oz);
        cfg_write(CFG_DIR_X, dx);
        cfg_write(CFG_DIR_Y, dy);
        cfg_write(CFG_DIR_Z, dz);
        cfg_write(CFG_THRESHOLD, thr);
        cfg_write(CFG_SPARE, $urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until everything sent has come back, then let the pipe drain
    task automatic drain();
        while (tri_pend.size() > 0 || tri_vld || mesh_hit_q.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic push_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                            int x2, int y2, int z2, bit last);
        tri_pend.push_back('{x0, y0, z0, x1, y1, z1, x2, y2, z2, last});
    endtask

    // triangles scattered around the ray so that roughly half are hit
    task automatic near_tris(int count);
        tri_t t;
        int   cx, cy, cz;
        for (int i = 0; i < count; i++) begin
            cx = near(3 * ONE);
            cy = near(3 * ONE);
            cz = near(8 * ONE);
            t.ax = cx + near(3 * ONE); t.ay = cy + near(3 * ONE);
            t.az = cz + near(ONE);
            t.bx = cx + near(3 * ONE); t.by = cy + near(3 * ONE);
            t.bz = cz + near(ONE);
            t.cx = cx + near(3 * ONE); t.cy = cy + near(3 * ONE);
            t.cz = cz + near(ONE);
            t.last = ($urandom_range(4) == 0) || (i == count - 1);
            tri_pend.push_back(t);
        end
    endtask

    // full-range coordinates, mostly misses but every bit exercised
    task automatic wild_tris(int count);
        tri_t t;
        for (int i = 0; i < count; i++) begin
            t = {$urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, 1'b0};
            t.last = ($urandom_range(3) == 0) || (i == count - 1);
            tri_pend.push_back(t);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    localparam int MAXP = 32'h7FFF_FFFF;
    localparam int MINN = 32'h8000_0000;

    initial begin
        rst_n          = 1'b0;
        tri_vld        = 1'b0;
        tri_out        = '0;
        res_rdy        = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        hit_acc        = 1'b0;
        send_idle      = 0;
        recv_stall     = 0;
        long_hold_req  = 1'b0;
        long_hold_done = 1'b0;
        hold_cnt       = 0;
        n_err          = 0;
        for (int i = 0; i < 7; i++) ray_reg[i] = '0;
        ray_reg[CFG_THRESHOLD] = 32'd1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset ray has zero direction: everything misses
        near_tris(20);
        drain();

        // ray from the origin along +z, no parallel cut
        cfg_ray(0, 0, 0, 0, 0, ONE, 0);
        push_tri(-ONE, -ONE, 2*ONE, ONE, -ONE, 2*ONE, 0, ONE, 2*ONE, 1);     // plain hit
        push_tri(-ONE, -ONE, -2*ONE, ONE, -ONE, -2*ONE, 0, ONE, -2*ONE, 1);  // behind origin
        push_tri(-ONE, 0, ONE, ONE, 0, ONE, 0, 0, 3*ONE, 1);                 // parallel
        push_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0, 1);                 // hit at t = 0
        push_tri(0, -ONE, 2*ONE, 0, ONE, 2*ONE, 2*ONE, 0, 2*ONE, 1);         // on an edge
        push_tri(0, 0, 2*ONE, ONE, 0, 2*ONE, 0, ONE, 2*ONE, 1);              // through a vertex
        push_tri(ONE, ONE, 2*ONE, 2*ONE, ONE, 2*ONE, ONE, 2*ONE, 2*ONE, 1);  // plane hit, outside
        push_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1);                              // degenerate
        push_tri(MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, 1);
        push_tri(MINN, MINN, MAXP, MAXP, MINN, MAXP, 0, MAXP, MAXP, 1);      // huge, hit
        push_tri(MINN, MINN, MINN, MAXP, MINN, MINN, 0, MAXP, MINN, 1);      // huge, behind
        push_tri(ONE, ONE, 2*ONE, 2*ONE, ONE, 2*ONE, ONE, 2*ONE, 2*ONE, 0);  // miss then
        push_tri(-ONE, -ONE, 2*ONE, ONE, -ONE, 2*ONE, 0, ONE, 2*ONE, 0);     // hit then
        push_tri(ONE, ONE, 2*ONE, 2*ONE, ONE, 2*ONE, ONE, 2*ONE, 2*ONE, 1);  // miss: sticky
        near_tris(200);
        drain();

        // tilted ray; block fills while the result side holds off
        cfg_ray(near(ONE), near(ONE), near(ONE), near(ONE / 4), near(ONE / 4),
                -ONE, $urandom_range(1000));
        send_idle     = 0;
        recv_stall    = 70;
        long_hold_req = 1'b1;
        near_tris(200);
        drain();

        // wide ray, largest threshold, sender idles
        cfg_ray(MINN, MAXP, MINN, MAXP, MINN, MAXP, 32'hFFFF_FFFF);
        send_idle  = 70;
        recv_stall = 0;
        wild_tris(150);
        drain();

        // random full-range ray, no threshold, both sides idle
        cfg_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
        send_idle  = 30;
        recv_stall = 30;
        wild_tris(150);
        drain();

        // near-ray triangles again under mixed idling
        cfg_ray(near(ONE), near(ONE), near(ONE), near(ONE / 4), near(ONE / 4),
                ONE, $urandom);
        near_tris(250);
        drain();

        if (n_err == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
